// File: src/skit_pkg.sv
// ----------------------------------------------------------------------------
// skit_pkg: shared types and constants of the sorted key index table
// Field widths, operation and status codes, and the compare result type.
// ----------------------------------------------------------------------------
package skit_pkg;

    localparam int KEY_W     = 20;
    localparam int SLOT_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // Result of the shared key comparator: a < b and a == b.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// File: src/skit_ram.sv
// ----------------------------------------------------------------------------
// skit_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/skit_cmp.sv
// ----------------------------------------------------------------------------
// skit_cmp: shared key comparator
// Compares two catalog keys; used by every scan of the sequencer.
// ----------------------------------------------------------------------------
module skit_cmp (
    input  logic [skit_pkg::KEY_W-1:0] a,
    input  logic [skit_pkg::KEY_W-1:0] b,
    output skit_pkg::cmp_res_t         res
);

    import skit_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

// File: src/sorted_key_index_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_index_table_unit: sorted key index over a dense record store
// Clear, a refused add and a miss on an empty table go straight to the
// reply; an add walks down from the top, moving each entry with a greater
// key up by one; a lookup scans up from the first entry until one is not
// below the key; a remove runs search, shift and moved-record fixup.
// A stalled reply holds the unit in FINISH until the reply before is taken.
// Throughput: one transaction at a time, set by the single index RAM port
// pair and the one shared comparator. Reset empties the table at once; the
// RAM contents are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module sorted_key_index_table_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [19:0] catalog_key, [23:20] zero
    input  logic [skit_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [skit_pkg::OP_W-1:0]      s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] slot, [16:8] entry_count, [23:17] zero
    output logic [skit_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [skit_pkg::STATUS_W-1:0]  m_axis_tuser
);

    import skit_pkg::*;

    // IW indexes the RAMs; CW holds a record count up to CAPACITY itself.
    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = IW + KEY_W;

    // The index RAM holds {slot, key} per entry, kept in ascending key order.
    // The store RAM holds the key of each record slot.
    typedef enum logic [2:0] {
        IDLE,
        ADD_EV,
        ADD_PUT,
        FIND_EV,
        SHIFT,
        REM_FIX,
        REM_MV,
        FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          p_reg, p_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [IW-1:0]          slot_reg, slot_next;
    op_t                    op_reg, op_next;
    logic                   moving_reg, moving_next;
    status_t                res_status_reg, res_status_next;
    logic [IW-1:0]          res_slot_reg, res_slot_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                   idx_we;
    logic [IW-1:0]          idx_wr_addr;
    logic [IDX_W-1:0]       idx_wr_data;
    logic [IW-1:0]          idx_rd_addr;
    logic [IDX_W-1:0]       idx_dout;

    logic                   sk_we;
    logic [IW-1:0]          sk_wr_addr;
    logic [KEY_W-1:0]       sk_wr_data;
    logic [IW-1:0]          sk_rd_addr;
    logic [KEY_W-1:0]       sk_dout;

    logic [KEY_W-1:0]       dout_key;
    logic [IW-1:0]          dout_slot;
    logic [KEY_W-1:0]       cmp_a;
    logic [KEY_W-1:0]       cmp_b;
    cmp_res_t               cmp_res;

    logic [CW-1:0]          last;
    logic [CW-1:0]          p_inc;
    logic [CW-1:0]          p_dec;
    logic [CW-1:0]          p_dec2;
    logic [CW:0]            p_inc2;
    op_t                    in_op;
    logic [KEY_W-1:0]       in_key;

    skit_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_index_ram (
        .clk     (clk),
        .we      (idx_we),
        .wr_addr (idx_wr_addr),
        .wr_data (idx_wr_data),
        .rd_addr (idx_rd_addr),
        .rd_data (idx_dout)
    );

    skit_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store_ram (
        .clk     (clk),
        .we      (sk_we),
        .wr_addr (sk_wr_addr),
        .wr_data (sk_wr_data),
        .rd_addr (sk_rd_addr),
        .rd_data (sk_dout)
    );

    // The one comparator serves every scan. The insertion scan asks whether
    // the new key sorts before an entry; the searches ask whether an entry
    // is still below the key being looked for.
    skit_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign dout_key  = idx_dout[KEY_W-1:0];
    assign dout_slot = idx_dout[KEY_W +: IW];
    assign cmp_a     = (state_reg == ADD_EV) ? key_reg  : dout_key;
    assign cmp_b     = (state_reg == ADD_EV) ? dout_key : key_reg;

    assign last   = cnt_reg - CW'(1);
    assign p_inc  = p_reg + CW'(1);
    assign p_dec  = p_reg - CW'(1);
    assign p_dec2 = p_reg - CW'(2);
    assign p_inc2 = {1'b0, p_reg} + (CW+1)'(2);

    assign in_op  = op_t'(s_axis_tuser);
    assign in_key = s_axis_tdata[KEY_W-1:0];

    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // Sequencer. Scans stream through the index RAM one entry per cycle: the
    // address of the next entry is presented while the current one, read in
    // the previous cycle, is evaluated.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        p_next          = p_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        op_next         = op_reg;
        moving_next     = moving_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        idx_we      = 1'b0;
        idx_wr_addr = p_reg[IW-1:0];
        idx_wr_data = idx_dout;
        idx_rd_addr = '0;
        sk_we       = 1'b0;
        sk_wr_addr  = cnt_reg[IW-1:0];
        sk_wr_data  = in_key;
        sk_rd_addr  = last[IW-1:0];

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = in_op;
                    key_next    = in_key;
                    moving_next = 1'b0;
                    p_next      = '0;
                    unique case (in_op)
                        OP_ADD:
                        begin
                            if (cnt_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                                res_slot_next   = '0;
                                state_next      = FINISH;
                            end
                            else
                            begin
                                // The new record takes the next free slot.
                                sk_we     = 1'b1;
                                slot_next = cnt_reg[IW-1:0];
                                p_next    = cnt_reg;
                                if (cnt_reg == '0)
                                begin
                                    state_next = ADD_PUT;
                                end
                                else
                                begin
                                    idx_rd_addr = last[IW-1:0];
                                    state_next  = ADD_EV;
                                end
                            end
                        end
                        OP_LOOKUP, OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                                res_slot_next   = '0;
                                state_next      = FINISH;
                            end
                            else
                            begin
                                idx_rd_addr = '0;
                                state_next  = FIND_EV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next        = '0;
                            res_status_next = STAT_OK;
                            res_slot_next   = '0;
                            state_next      = FINISH;
                        end
                    endcase
                end
            end

            ADD_EV:
            begin
                // Walk down from the top: entries with a greater key move up
                // by one, so the new pair lands after any equal keys.
                if (cmp_res.lt)
                begin
                    idx_we      = 1'b1;
                    idx_wr_data = idx_dout;
                    p_next      = p_dec;
                    if (p_reg == CW'(1))
                    begin
                        state_next = ADD_PUT;
                    end
                    else
                    begin
                        idx_rd_addr = p_dec2[IW-1:0];
                    end
                end
                else
                begin
                    state_next = ADD_PUT;
                end
            end

            ADD_PUT:
            begin
                idx_we          = 1'b1;
                idx_wr_data     = {slot_reg, key_reg};
                cnt_next        = cnt_reg + CW'(1);
                res_status_next = STAT_OK;
                res_slot_next   = slot_reg;
                state_next      = FINISH;
            end

            FIND_EV:
            begin
                if (!cmp_res.lt)
                begin
                    if (cmp_res.eq)
                    begin
                        if (moving_reg)
                        begin
                            // Point the first entry with the moved key at the
                            // freed slot.
                            idx_we          = 1'b1;
                            idx_wr_data     = {slot_reg, dout_key};
                            res_status_next = STAT_OK;
                            res_slot_next   = slot_reg;
                            state_next      = FINISH;
                        end
                        else if (op_reg == OP_LOOKUP)
                        begin
                            res_status_next = STAT_OK;
                            res_slot_next   = dout_slot;
                            state_next      = FINISH;
                        end
                        else
                        begin
                            slot_next = dout_slot;
                            if (p_inc < cnt_reg)
                            begin
                                idx_rd_addr = p_inc[IW-1:0];
                                state_next  = SHIFT;
                            end
                            else
                            begin
                                state_next = REM_FIX;
                            end
                        end
                    end
                    else
                    begin
                        res_status_next = moving_reg ? STAT_OK : STAT_NOT_FOUND;
                        res_slot_next   = moving_reg ? slot_reg : '0;
                        state_next      = FINISH;
                    end
                end
                else if (p_inc == cnt_reg)
                begin
                    res_status_next = moving_reg ? STAT_OK : STAT_NOT_FOUND;
                    res_slot_next   = moving_reg ? slot_reg : '0;
                    state_next      = FINISH;
                end
                else
                begin
                    idx_rd_addr = p_inc[IW-1:0];
                    p_next      = p_inc;
                end
            end

            SHIFT:
            begin
                // Close the gap: entry p+1 moves down to p.
                idx_we      = 1'b1;
                idx_wr_data = idx_dout;
                p_next      = p_inc;
                if (p_inc2 < {1'b0, cnt_reg})
                begin
                    idx_rd_addr = p_inc2[IW-1:0];
                end
                else
                begin
                    state_next = REM_FIX;
                end
            end

            REM_FIX:
            begin
                cnt_next = last;
                if (CW'(slot_reg) < last)
                begin
                    sk_rd_addr = last[IW-1:0];
                    state_next = REM_MV;
                end
                else
                begin
                    // The freed slot was the last one (or beyond it).
                    res_status_next = STAT_OK;
                    res_slot_next   = slot_reg;
                    state_next      = FINISH;
                end
            end

            REM_MV:
            begin
                // The last record moves into the freed slot, then its first
                // index entry is searched for.
                sk_we       = 1'b1;
                sk_wr_addr  = slot_reg;
                sk_wr_data  = sk_dout;
                key_next    = sk_dout;
                moving_next = 1'b1;
                p_next      = '0;
                idx_rd_addr = '0;
                state_next  = FIND_EV;
            end

            FINISH:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {(M_TDATA_W - SLOT_W - COUNT_W)'(0),
                                     COUNT_W'(cnt_reg), SLOT_W'(res_slot_reg)};
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            moving_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            moving_reg   <= moving_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// File: verif/tb_sorted_key_index_table_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_index_table_unit: self-checking bench of the sorted key index
// Each accepted command is run through a behavioral copy of the table: the
// key index, the dense slot store and the record count. The reply that the
// copy predicts is queued and matched, field by field, with the reply stream.
// Directed cases, a fill to full capacity and long random runs, which lean on
// repeated keys, are sent with random gaps and random back pressure.
// ----------------------------------------------------------------------------
module tb_sorted_key_index_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import skit_pkg::*;

    localparam int CAP        = 256;
    localparam int POOL_SIZE  = 12;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } table_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // Behavioral copy of the table.
    logic [KEY_W-1:0]       mirror_idx_key [CAP];
    int                     mirror_idx_slot [CAP];
    logic [KEY_W-1:0]       mirror_slot_key [CAP];
    int                     mirror_count = 0;

    table_reply_t           pending_replies [$];
    logic [KEY_W-1:0]       key_pool [POOL_SIZE];
    int                     errors = 0;
    int                     idle_cycles = 0;
    int                     stall_left = 0;
    bit                     steady = 1'b0;

    sorted_key_index_table_unit #(
        .CAPACITY      (CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Keys mostly come from a small pool so that duplicates are common.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    function automatic op_t pick_op(int add_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_weight)
            return OP_ADD;
        if (r < add_weight + 25)
            return OP_LOOKUP;
        if (r < 95)
            return OP_REMOVE;
        return OP_CLEAR;
    endfunction

    // Index of the first index entry equal to key, or the count if none.
    function automatic int first_index_of(logic [KEY_W-1:0] key);
        int i;
        i = 0;
        while (i < mirror_count && mirror_idx_key[i] < key)
            i++;
        if (i < mirror_count && mirror_idx_key[i] == key)
            return i;
        return mirror_count;
    endfunction

    function automatic table_reply_t apply_table_op(op_t op, logic [KEY_W-1:0] key);
        table_reply_t reply;
        int pos;
        int i;
        int slot;
        int last;
        logic [KEY_W-1:0] moved;
        reply.status = STAT_OK;
        slot = 0;
        case (op)
            OP_ADD:
            begin
                if (mirror_count >= CAP)
                    reply.status = STAT_FULL;
                else
                begin
                    slot = mirror_count;
                    mirror_slot_key[slot] = key;
                    // New key goes after every equal key.
                    pos = 0;
                    while (pos < mirror_count && mirror_idx_key[pos] <= key)
                        pos++;
                    for (i = mirror_count; i > pos; i--)
                    begin
                        mirror_idx_key[i]  = mirror_idx_key[i - 1];
                        mirror_idx_slot[i] = mirror_idx_slot[i - 1];
                    end
                    mirror_idx_key[pos]  = key;
                    mirror_idx_slot[pos] = slot;
                    mirror_count++;
                end
            end
            OP_LOOKUP:
            begin
                pos = first_index_of(key);
                if (pos >= mirror_count)
                    reply.status = STAT_NOT_FOUND;
                else
                    slot = mirror_idx_slot[pos];
            end
            OP_REMOVE:
            begin
                pos = first_index_of(key);
                if (pos >= mirror_count)
                    reply.status = STAT_NOT_FOUND;
                else
                begin
                    slot = mirror_idx_slot[pos];
                    last = mirror_count - 1;
                    for (i = pos; i < last; i++)
                    begin
                        mirror_idx_key[i]  = mirror_idx_key[i + 1];
                        mirror_idx_slot[i] = mirror_idx_slot[i + 1];
                    end
                    mirror_count = last;
                    // The last record fills the hole; a stale slot moves nothing.
                    if (slot < last)
                    begin
                        moved = mirror_slot_key[last];
                        mirror_slot_key[slot] = moved;
                        pos = first_index_of(moved);
                        if (pos < mirror_count)
                            mirror_idx_slot[pos] = slot;
                    end
                end
            end
            default:
            begin
                mirror_count = 0;
            end
        endcase
        reply.slot  = SLOT_W'(slot);
        reply.count = COUNT_W'(mirror_count);
        return reply;
    endfunction

    // Sends one command. Valid stays high after the transaction so that a
    // back-to-back command never lowers and raises it in the same step.
    task automatic send_item(op_t op, logic [KEY_W-1:0] key);
        int gap;
        table_reply_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, key};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_table_op(op, key);
        pending_replies.insert(pending_replies.size(), predicted);
    endtask

    // Holds the command stream off until every outstanding reply is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // Empty table: lookup and remove both miss.
        send_item(OP_LOOKUP, 20'h00000);
        send_item(OP_REMOVE, 20'hFFFFF);
        // Extreme keys, a duplicate and first-match lookups.
        send_item(OP_ADD, 20'h00000);
        send_item(OP_ADD, 20'hFFFFF);
        send_item(OP_ADD, 20'h00000);
        send_item(OP_LOOKUP, 20'h00000);
        send_item(OP_LOOKUP, 20'hFFFFF);
        send_item(OP_LOOKUP, 20'h5A5A5);
        // Removing the last slot moves nothing.
        send_item(OP_ADD, 20'h80000);
        send_item(OP_REMOVE, 20'h80000);
        // Removing slot zero moves the last record into it.
        send_item(OP_REMOVE, 20'h00000);
        send_item(OP_LOOKUP, 20'h00000);
        // Clear with a nonzero key, which is ignored.
        send_item(OP_CLEAR, 20'hA5A5A);
        send_item(OP_LOOKUP, 20'hFFFFF);
        // Build a stale index entry: the fixup repoints the first B entry,
        // leaving the second one naming a slot past the end of the store.
        send_item(OP_ADD, 20'h00111);
        send_item(OP_ADD, 20'h00222);
        send_item(OP_ADD, 20'h00222);
        send_item(OP_REMOVE, 20'h00111);
        send_item(OP_ADD, 20'h00333);
        send_item(OP_REMOVE, 20'h00222);
        send_item(OP_REMOVE, 20'h00222);
        send_item(OP_LOOKUP, 20'h00333);
        send_item(OP_CLEAR, 20'h00000);
    endtask

    task automatic test_fill_full();
        int i;
        op_t op;
        send_item(OP_CLEAR, pick_key());
        for (i = 0; i < CAP; i++)
            send_item(OP_ADD, pick_key());
        // Store full: the add is refused and nothing changes.
        send_item(OP_ADD, 20'hFFFFF);
        send_item(OP_LOOKUP, key_pool[0]);
        send_item(OP_REMOVE, key_pool[1]);
        send_item(OP_ADD, 20'h00000);
        send_item(OP_ADD, 20'h00001);
        // Hover near capacity, where shifts and fixups are longest.
        for (i = 0; i < 30; i++)
        begin
            op = pick_op(45);
            if (op == OP_CLEAR)
                op = OP_REMOVE;
            send_item(op, pick_key());
        end
    endtask

    task automatic test_random(int items);
        int i;
        for (i = 0; i < items; i++)
            send_item(pick_op(40), pick_key());
    endtask

    initial
    begin
        int i;
        for (i = 0; i < CAP; i++)
        begin
            mirror_idx_key[i]  = '0;
            mirror_idx_slot[i] = 0;
            mirror_slot_key[i] = '0;
        end
        key_pool[0] = 20'h00000;
        key_pool[1] = 20'hFFFFF;
        for (i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_full();
        test_random(250);
        // A stretch with no idling on either side.
        steady = 1'b1;
        test_random(120);
        steady = 1'b0;
        wait_drained();
        test_random(330);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_sorted_key_index_table_unit OK");
        else
            $display("tb_sorted_key_index_table_unit NOT OK");
        $finish;
    end

    // Reply side back pressure: random stalls, most of them short.
    always @(posedge clk)
    begin
        if (steady)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Each reply transaction is matched with the oldest prediction.
    always @(posedge clk)
    begin : check_reply
        table_reply_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, actual status %0d slot %0d count %0d",
                         $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8]);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:0] !== want.slot)
                begin
                    $display("%0t: slot mismatch, expected %0d actual %0d",
                             $time, want.slot, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[16:8] !== want.count)
                begin
                    $display("%0t: entry count mismatch, expected %0d actual %0d",
                             $time, want.count, m_axis_tdata[16:8]);
                    errors++;
                end
                if (m_axis_tdata[23:17] !== '0)
                begin
                    $display("%0t: padding mismatch, expected 0 actual %0h",
                             $time, m_axis_tdata[23:17]);
                    errors++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side moves a transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_sorted_key_index_table_unit NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: filelist.f
src/skit_pkg.sv
src/skit_ram.sv
src/skit_cmp.sv
src/sorted_key_index_table_unit.sv
verif/tb_sorted_key_index_table_unit.sv
